/* rtl/ftwm_pkg.sv */
// shared types and constants of the frame time window monitor
// no dependencies; imported by the top level and the port checker
package ftwm_pkg;

   localparam int SAMPLE_W   = 24;   // frame time and threshold width
   localparam int COUNT_W    = 32;   // wrapping event counters
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 176;
   localparam int BIT_IDX_W  = 5;    // selects one bit of a sample-wide word
   localparam int GRADE_BITS = 27;   // width of 5*avg and 6*target
   localparam int MOD_W      = 8;
   localparam int CLEAR_PERIOD = 180;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL = 2'd2;

   localparam logic [SAMPLE_W-1:0] TARGET_RESET   = 24'd16667;
   localparam logic [SAMPLE_W-1:0] WARNING_RESET  = 24'd20000;
   localparam logic [SAMPLE_W-1:0] CRITICAL_RESET = 24'd33333;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 24'hFFFFFF;

   localparam logic [1:0] GRADE_ON_TARGET  = 2'd0;
   localparam logic [1:0] GRADE_WITHIN_1P2 = 2'd1;
   localparam logic [1:0] GRADE_WITHIN_1P5 = 2'd2;
   localparam logic [1:0] GRADE_OVER       = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_GRADE,
      ST_DONE
   } state_type;

   // one result, last field in the lowest bits
   typedef struct packed {
      logic [1:0]          grade;
      logic                is_good;
      logic                alert_active;
      logic [COUNT_W-1:0]  criticals_seen;
      logic [COUNT_W-1:0]  warnings_seen;
      logic [COUNT_W-1:0]  frames_seen;
      logic [SAMPLE_W-1:0] max_time_us;
      logic [SAMPLE_W-1:0] min_time_us;
      logic [SAMPLE_W-1:0] window_average_us;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

/* rtl/frame_time_window_monitor.sv */
// per sample: one serial pass over the SUM_W = 24+clog2(depth) sum bits for the ring sum
//   and compares, one for the divider, then serial grading over GRADE_BITS bits
// an input transfer is taken only in idle; a finished result waits in the output register
// reset (synchronous, active high) restores register defaults and clears all counters;
//   the history memory is not swept, a fill flag masks slots not yet written
module frame_time_window_monitor #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ftwm_pkg::REQ_DATA_W-1:0]    req_tdata,   // [23:0] frame_time_us
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [23:0] window_average_us, [47:24] min_time_us, [71:48] max_time_us,
   // [103:72] frames_seen, [135:104] warnings_seen, [167:136] criticals_seen,
   // [168] alert_active, [169] is_good, [171:170] grade, [175:172] zero
   output logic [ftwm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration writes
   input  logic                               csr_we,
   input  logic [ftwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ftwm_pkg::SAMPLE_W-1:0]      csr_wdata
);

   import ftwm_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int DIV_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int CNT_W  = $clog2(SUM_W);

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [DIV_W-1:0]  DEPTH_DIV  = DIV_W'(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0]  SUM_LAST   = CNT_W'(SUM_W - 1);
   localparam logic [CNT_W-1:0]  GRADE_LAST = CNT_W'(GRADE_BITS - 1);
   localparam logic [CNT_W-1:0]  SAMPLE_END = CNT_W'(SAMPLE_W);
   localparam logic [MOD_W-1:0]  CLEAR_LAST = MOD_W'(CLEAR_PERIOD - 1);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] target_ff;
   logic [SAMPLE_W-1:0] warning_ff;
   logic [SAMPLE_W-1:0] critical_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         warning_ff  <= WARNING_RESET;
         critical_ff <= CRITICAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET:   target_ff   <= csr_wdata;
            CSR_WARNING:  warning_ff  <= csr_wdata;
            CSR_CRITICAL: critical_ff <= csr_wdata;
            default: ;    // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   state_type  state_ff, state_in;
   logic       div_start;
   logic       div_done;
   logic       out_load;
   logic       req_xfer;
   logic       rsp_tvalid_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign req_xfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (cnt_ff == SUM_LAST) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_GRADE;
         end
         ST_GRADE: begin
            if (cnt_ff == GRADE_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the output register is free or being drained
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // bit counter shared by the serial sum pass and the grading pass
   logic [BIT_IDX_W-1:0] bit_sel;
   logic                 in_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_in == state_ff &&
                   (state_ff == ST_SUM || state_ff == ST_GRADE)) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else begin
         cnt_ff <= '0;
      end
   end

   assign bit_sel = cnt_ff[BIT_IDX_W-1:0];
   assign in_bits = cnt_ff < SAMPLE_END;   // above the sample width every bit reads zero

   // ---------------------------------------------------------------------
   // history ring and frame counters, all updated at the input transfer
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] hist_mem [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] old_ff;        // sample leaving the window
   logic                old_valid_ff;  // slot was written before
   logic [SAMPLE_W-1:0] x_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                full_ff;       // ring has wrapped once since reset
   logic [COUNT_W-1:0]  frame_total_ff;
   logic [COUNT_W-1:0]  frame_next;
   logic [MOD_W-1:0]    mod_ff;        // frame_total mod 180, restarted when the frame counter wraps
   logic [DIV_W-1:0]    divisor_ff;
   logic                frame_small;

   // read old value and write new one at the same slot in the same cycle
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         old_ff            <= hist_mem[slot_ff];
         hist_mem[slot_ff] <= req_tdata;
      end
   end

   assign frame_next  = frame_total_ff + COUNT_W'(1);
   // divisor is the frame count while it is still below the depth and nonzero
   assign frame_small = (frame_next[COUNT_W-1:DIV_W] == '0) &&
                        (frame_next[DIV_W-1:0] != '0) &&
                        (frame_next[DIV_W-1:0] < DEPTH_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= '0;
         full_ff        <= 1'b0;
         frame_total_ff <= '0;
         mod_ff         <= '0;
      end else if (req_xfer) begin
         slot_ff        <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
         if (slot_ff == LAST_SLOT) full_ff <= 1'b1;
         frame_total_ff <= frame_next;
         // the frame counter wrap lands on zero, which is a multiple of the period
         if (frame_next == '0 || mod_ff == CLEAR_LAST) mod_ff <= '0;
         else                                           mod_ff <= mod_ff + MOD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff         <= req_tdata;
         old_valid_ff <= full_ff;
         divisor_ff   <= frame_small ? frame_next[DIV_W-1:0] : DEPTH_DIV;
      end
   end

   // ---------------------------------------------------------------------
   // serial pass 1: window sum update and sample compares, lsb first
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0] sum_sr_ff;
   logic [1:0]       sum_cy_ff;
   logic [2:0]       sum_total;
   logic [SUM_W-1:0] sum_new;
   logic             xb, ob, crb, wnb, tgb, mnb, mxb;
   logic             gt_crit_ff, gt_warn_ff, gt_tgt_ff, lt_min_ff, gt_max_ff;

   logic [SAMPLE_W-1:0] min_ff, max_ff;
   logic [COUNT_W-1:0]  warn_total_ff, crit_total_ff;
   logic                alert_ff;

   always_comb begin
      xb  = in_bits & x_ff[bit_sel];
      ob  = in_bits & old_valid_ff & old_ff[bit_sel];
      crb = in_bits & critical_ff[bit_sel];
      wnb = in_bits & warning_ff[bit_sel];
      tgb = in_bits & target_ff[bit_sel];
      mnb = in_bits & min_ff[bit_sel];
      mxb = in_bits & max_ff[bit_sel];
      // sum + x + ~old + 1, carry of up to two
      sum_total = {2'b00, sum_sr_ff[0]} + {2'b00, xb} + {2'b00, ~ob} + {1'b0, sum_cy_ff};
      sum_new   = {sum_total[0], sum_sr_ff[SUM_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_sr_ff <= '0;
      end else if (state_ff == ST_SUM) begin
         sum_sr_ff <= sum_new;
      end
   end

   // a later differing bit overrides an earlier one, so the msb decides
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sum_cy_ff  <= 2'd1;
         gt_crit_ff <= 1'b0;
         gt_warn_ff <= 1'b0;
         gt_tgt_ff  <= 1'b0;
         lt_min_ff  <= 1'b0;
         gt_max_ff  <= 1'b0;
      end else if (state_ff == ST_SUM) begin
         sum_cy_ff <= sum_total[2:1];
         if (xb != crb) gt_crit_ff <= xb;
         if (xb != wnb) gt_warn_ff <= xb;
         if (xb != tgb) gt_tgt_ff  <= xb;
         if (xb != mnb) lt_min_ff  <= mnb;
         if (xb != mxb) gt_max_ff  <= xb;
      end
   end

   // statistics update at the end of the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff        <= SAMPLE_MAX;
         max_ff        <= '0;
         warn_total_ff <= '0;
         crit_total_ff <= '0;
         alert_ff      <= 1'b0;
      end else if (div_start) begin
         if (lt_min_ff) min_ff <= x_ff;
         if (gt_max_ff) max_ff <= x_ff;
         if (gt_crit_ff)      crit_total_ff <= crit_total_ff + COUNT_W'(1);
         else if (gt_warn_ff) warn_total_ff <= warn_total_ff + COUNT_W'(1);
         // periodic clear wins over a critical set in the same frame
         if (!gt_tgt_ff && mod_ff == '0) alert_ff <= 1'b0;
         else if (gt_crit_ff)             alert_ff <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // serial pass 2: window mean
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0]    quotient;
   logic [SAMPLE_W-1:0] avg_ff;

   ftwm_serial_div #(
      .DVD_W (SUM_W),
      .DVS_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // mean can exceed the sample range right after the frame counter wraps
   always_ff @(posedge clock) begin
      if (div_done) begin
         avg_ff <= (quotient[SUM_W-1:SAMPLE_W] != '0) ? SAMPLE_MAX
                                                     : quotient[SAMPLE_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // serial pass 3: grade, comparing avg:t, 5avg:6t and 2avg:3t lsb first
   // ---------------------------------------------------------------------
   logic       ab, tb;
   logic       a_d1_ff, a_d2_ff, t_d1_ff, t_d2_ff;
   logic       c5_ff, c6_ff, c3_ff;
   logic       g1_ff, g5_ff, g2_ff;   // greater-than flags of the three compares
   logic [1:0] s5, s6, s3;
   logic [1:0] grade_val;

   always_comb begin
      ab = in_bits & avg_ff[bit_sel];
      tb = in_bits & target_ff[bit_sel];
      s5 = {1'b0, ab}      + {1'b0, a_d2_ff} + {1'b0, c5_ff};   // avg + 4avg
      s6 = {1'b0, t_d1_ff} + {1'b0, t_d2_ff} + {1'b0, c6_ff};   // 2t + 4t
      s3 = {1'b0, tb}      + {1'b0, t_d1_ff} + {1'b0, c3_ff};   // t + 2t
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         a_d1_ff <= 1'b0;
         a_d2_ff <= 1'b0;
         t_d1_ff <= 1'b0;
         t_d2_ff <= 1'b0;
         c5_ff   <= 1'b0;
         c6_ff   <= 1'b0;
         c3_ff   <= 1'b0;
         g1_ff   <= 1'b0;
         g5_ff   <= 1'b0;
         g2_ff   <= 1'b0;
      end else if (state_ff == ST_GRADE) begin
         a_d1_ff <= ab;
         a_d2_ff <= a_d1_ff;
         t_d1_ff <= tb;
         t_d2_ff <= t_d1_ff;
         c5_ff   <= s5[1];
         c6_ff   <= s6[1];
         c3_ff   <= s3[1];
         if (ab != tb)          g1_ff <= ab;
         if (s5[0] != s6[0])    g5_ff <= s5[0];
         if (a_d1_ff != s3[0])  g2_ff <= a_d1_ff;
      end
   end

   always_comb begin
      if (!g1_ff)      grade_val = GRADE_ON_TARGET;
      else if (!g5_ff) grade_val = GRADE_WITHIN_1P2;
      else if (!g2_ff) grade_val = GRADE_WITHIN_1P5;
      else             grade_val = GRADE_OVER;
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   result_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.window_average_us <= avg_ff;
         rsp_data_ff.min_time_us       <= min_ff;
         rsp_data_ff.max_time_us       <= max_ff;
         rsp_data_ff.frames_seen       <= frame_total_ff;
         rsp_data_ff.warnings_seen     <= warn_total_ff;
         rsp_data_ff.criticals_seen    <= crit_total_ff;
         rsp_data_ff.alert_active      <= alert_ff;
         rsp_data_ff.is_good           <= !g1_ff && (crit_total_ff == '0);
         rsp_data_ff.grade             <= grade_val;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RESULT_W)'(0), rsp_data_ff};

endmodule

/* rtl/ftwm_serial_div.sv */
// restoring divider, one quotient bit per cycle, msb first
// standalone; instantiated by frame_time_window_monitor
module ftwm_serial_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;

   logic [DVS_W:0]   partial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   // remainder stays below the divisor, so the partial fits one extra bit
   always_comb begin
      partial = {rem_ff, dvd_ff[DVD_W-1]};
      fits    = partial >= {1'b0, dvs_ff};
      diff    = partial - {1'b0, dvs_ff};
      rem_in  = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient bits shift in behind the dividend
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* rtl/ftwm_checker.sv */
// port-level checks for frame_time_window_monitor
// depends on ftwm_pkg; bound to the top level at the end of this file
module ftwm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ftwm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ftwm_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one sample at a time: no transfer on the cycle after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a sample is in work");

   // every result follows at least one sample, so min never exceeds max
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:24] <= rsp_tdata[71:48])
      else $error("min above max");

   // good implies the on-target grade
   a_good_grade: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[169] |-> rsp_tdata[171:170] == GRADE_ON_TARGET)
      else $error("good result with a grade above target");

endmodule

bind frame_time_window_monitor ftwm_checker u_ftwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/tb_top.sv */
// self-checking testbench for the frame time window monitor: sends frame time samples,
// predicts every result (window average, min/max, event counts, alert, grade) in place
// depends on rtl/ftwm_pkg.sv and rtl/frame_time_window_monitor.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ftwm_pkg::*;

   localparam int HISTORY_DEPTH = 64;
   localparam int SLOT_BITS     = $clog2(HISTORY_DEPTH);
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 120;   // idle time after the final drain, to catch stray results

   // clock, reset and block ports; every input starts at a known value
   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;   // [23:0] frame_time_us
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [23:0] window_average_us, [47:24] min_time_us, [71:48] max_time_us,
   // [103:72] frames_seen, [135:104] warnings_seen, [167:136] criticals_seen,
   // [168] alert_active, [169] is_good, [171:170] grade, [175:172] zero
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [SAMPLE_W-1:0]     csr_wdata  = '0;

   // idle percentages of the two sides, changed between test phases
   int send_idle_pct = 25;
   int recv_idle_pct = 69;

   int mismatch_count = 0;
   int result_count   = 0;
   int cycle_count    = 0;

   // results predicted for accepted samples, oldest first
   result_type predicted_results[$];

   // monitor state as the predictor sees it
   logic [SAMPLE_W-1:0] ring_samples [HISTORY_DEPTH];
   logic [SLOT_BITS-1:0] ring_slot;
   logic [63:0]         ring_sum;
   logic [COUNT_W-1:0]  frame_count;
   logic [SAMPLE_W-1:0] min_time;
   logic [SAMPLE_W-1:0] max_time;
   logic [COUNT_W-1:0]  warn_count;
   logic [COUNT_W-1:0]  crit_count;
   logic                alert_latched;
   // budget registers as last written
   logic [SAMPLE_W-1:0] target_us;
   logic [SAMPLE_W-1:0] warning_us;
   logic [SAMPLE_W-1:0] critical_us;

   frame_time_window_monitor #(
      .WINDOW_DEPTH (HISTORY_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  predicted_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // receiver side: stall at random, driven on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_predictor();
      foreach (ring_samples[i])
         ring_samples[i] = '0;
      ring_slot     = '0;
      ring_sum      = '0;
      frame_count   = '0;
      min_time      = SAMPLE_MAX;
      max_time      = '0;
      warn_count    = '0;
      crit_count    = '0;
      alert_latched = 1'b0;
      target_us     = TARGET_RESET;
      warning_us    = WARNING_RESET;
      critical_us   = CRITICAL_RESET;
   endfunction

   // window mean that the next sample would produce, state left untouched
   function automatic logic [SAMPLE_W-1:0] average_after(input logic [SAMPLE_W-1:0] sample);
      logic [COUNT_W-1:0] frames;
      logic [63:0]        sum;
      logic [63:0]        divisor;
      logic [63:0]        mean;
      frames  = frame_count + COUNT_W'(1);
      sum     = ring_sum - 64'(ring_samples[ring_slot]) + 64'(sample);
      divisor = (frames < COUNT_W'(HISTORY_DEPTH)) ? 64'(frames) : 64'(HISTORY_DEPTH);
      // counter wrapped to zero: the ring is full by then
      if (divisor == 64'd0)
         divisor = 64'(HISTORY_DEPTH);
      mean = sum / divisor;
      return (mean > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : mean[SAMPLE_W-1:0];
   endfunction

   // advance the monitor state by one sample and build the matching result
   function automatic result_type predict_result(input logic [SAMPLE_W-1:0] sample);
      result_type  r;
      logic [63:0] mean;
      logic [63:0] target;
      mean   = 64'(average_after(sample));
      target = 64'(target_us);

      frame_count = frame_count + COUNT_W'(1);
      ring_sum    = ring_sum - 64'(ring_samples[ring_slot]) + 64'(sample);
      ring_samples[ring_slot] = sample;
      ring_slot   = (ring_slot == SLOT_BITS'(HISTORY_DEPTH - 1)) ? '0
                                                                 : ring_slot + SLOT_BITS'(1);

      if (sample < min_time)
         min_time = sample;
      if (sample > max_time)
         max_time = sample;

      // critical wins over warning; a critical sample latches the alert
      if (sample > critical_us) begin
         crit_count    = crit_count + COUNT_W'(1);
         alert_latched = 1'b1;
      end else if (sample > warning_us) begin
         warn_count = warn_count + COUNT_W'(1);
      end
      // periodic clear, may undo a latch from this very sample
      if (sample <= target_us && (frame_count % CLEAR_PERIOD) == 0)
         alert_latched = 1'b0;

      // exact integer forms of 1.2x and 1.5x target
      if (mean <= target)
         r.grade = GRADE_ON_TARGET;
      else if (mean * 64'd5 <= target * 64'd6)
         r.grade = GRADE_WITHIN_1P2;
      else if (mean * 64'd2 <= target * 64'd3)
         r.grade = GRADE_WITHIN_1P5;
      else
         r.grade = GRADE_OVER;

      r.window_average_us = mean[SAMPLE_W-1:0];
      r.min_time_us       = min_time;
      r.max_time_us       = max_time;
      r.frames_seen       = frame_count;
      r.warnings_seen     = warn_count;
      r.criticals_seen    = crit_count;
      r.alert_active      = alert_latched;
      r.is_good           = (mean <= target) && (crit_count == 0);
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   result_count, name, got, want));
   endtask

   // every result transfer is checked against the oldest prediction
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RESULT_W-1:0];
         if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                      result_count));
         end else begin
            want = predicted_results.pop_front();
            compare_field("window_average_us", 32'(got.window_average_us),
                          32'(want.window_average_us));
            compare_field("min_time_us", 32'(got.min_time_us), 32'(want.min_time_us));
            compare_field("max_time_us", 32'(got.max_time_us), 32'(want.max_time_us));
            compare_field("frames_seen", got.frames_seen, want.frames_seen);
            compare_field("warnings_seen", got.warnings_seen, want.warnings_seen);
            compare_field("criticals_seen", got.criticals_seen, want.criticals_seen);
            compare_field("alert_active", 32'(got.alert_active), 32'(want.alert_active));
            compare_field("is_good", 32'(got.is_good), 32'(want.is_good));
            compare_field("grade", 32'(got.grade), 32'(want.grade));
         end
         // filler above the packed result must stay zero
         compare_field("pad bits", 32'(rsp_tdata[RSP_DATA_W-1:RESULT_W]), '0);
         result_count++;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one sample transfer; starts just after a rising edge, returns at the accepting edge
   task automatic send_frame_time(input logic [SAMPLE_W-1:0] sample);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do
         @(posedge clock);
      while (!req_tready);
      predicted_results.push_back(predict_result(sample));
   endtask

   // drop valid and hold off until every predicted result has come back
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predicted_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all three budget registers back to back; only called while idle
   task automatic set_thresholds(input logic [SAMPLE_W-1:0] target,
                                 input logic [SAMPLE_W-1:0] warning,
                                 input logic [SAMPLE_W-1:0] critical);
      logic [CSR_IDX_W-1:0] idx  [3] = '{CSR_TARGET, CSR_WARNING, CSR_CRITICAL};
      logic [SAMPLE_W-1:0]  vals [3];
      vals = '{target, warning, critical};
      foreach (idx[i]) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      @(negedge clock);
      csr_we      <= 1'b0;
      target_us   = target;
      warning_us  = warning;
      critical_us = critical;
   endtask

   // random samples shaped around the current budget
   task automatic run_random_frames(input int count);
      int                  sel;
      int                  v;
      longint              hi;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] thr;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         hi  = longint'((critical_us > target_us) ? critical_us : target_us);
         hi  = 2 * hi + 64;
         if (hi > longint'(SAMPLE_MAX))
            hi = longint'(SAMPLE_MAX);
         if (((frame_count + 1) % CLEAR_PERIOD) == 0 && $urandom_range(1)) begin
            // clearing frame: favor a sample at or under target
            sample = SAMPLE_W'($urandom_range(target_us));
         end else if (sel < 10) begin
            case ($urandom_range(3))
               0:       sample = '0;
               1:       sample = 24'd1;
               2:       sample = SAMPLE_MAX - 24'd1;
               default: sample = SAMPLE_MAX;
            endcase
         end else if (sel < 22) begin
            // on a threshold or one off either side of it
            case ($urandom_range(2))
               0:       thr = target_us;
               1:       thr = warning_us;
               default: thr = critical_us;
            endcase
            v = int'(thr) + int'($urandom_range(2)) - 1;
            if (v < 0)
               v = 0;
            if (v > int'(SAMPLE_MAX))
               v = int'(SAMPLE_MAX);
            sample = SAMPLE_W'(v);
         end else if (sel < 37) begin
            sample = SAMPLE_W'($urandom_range(SAMPLE_MAX));
         end else begin
            sample = SAMPLE_W'($urandom_range(32'(hi)));
         end
         send_frame_time(sample);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // reset budget: samples on and just above each threshold, plus the field extremes
   task automatic test_threshold_edges();
      logic [SAMPLE_W-1:0] samples [8];
      samples = '{24'd16667, 24'd0, 24'd16668, 24'd20000, 24'd20001,
                  24'd33333, 24'd33334, SAMPLE_MAX};
      foreach (samples[i])
         send_frame_time(samples[i]);
   endtask

   // target placed on each side of the 1x, 1.2x and 1.5x grade edges
   task automatic test_grade_boundaries();
      logic [SAMPLE_W-1:0] sample;
      logic [63:0]         mean;
      logic [63:0]         target;
      sample = 24'd30000;
      for (int k = 0; k < 6; k++) begin
         wait_results_drained();
         mean = 64'(average_after(sample));
         case (k)
            0:       target = mean;
            1:       target = mean - 1;
            2:       target = (5 * mean + 5) / 6;
            3:       target = (5 * mean + 5) / 6 - 1;
            4:       target = (2 * mean + 2) / 3;
            default: target = (2 * mean + 2) / 3 - 1;
         endcase
         set_thresholds(target[SAMPLE_W-1:0], warning_us, critical_us);
         send_frame_time(sample);
      end
   endtask

   task automatic test_default_budget();
      wait_results_drained();
      set_thresholds(TARGET_RESET, WARNING_RESET, CRITICAL_RESET);
      run_random_frames(228);
   endtask

   // everything but a zero sample counts as a warning, nothing is critical
   task automatic test_saturated_thresholds();
      wait_results_drained();
      set_thresholds(SAMPLE_MAX, '0, SAMPLE_MAX);
      run_random_frames(228);
   endtask

   // every nonzero sample is critical; only a zero sample can clear the alert
   task automatic test_zero_thresholds();
      wait_results_drained();
      set_thresholds('0, SAMPLE_MAX, '0);
      run_random_frames(228);
   endtask

   // critical below target: a clearing frame can undo its own latch
   task automatic test_critical_under_target();
      wait_results_drained();
      set_thresholds(24'd500000, 24'd200000, 24'd100000);
      run_random_frames(228);
   endtask

   task automatic test_random_thresholds();
      logic [SAMPLE_W-1:0] target;
      logic [SAMPLE_W-1:0] warning;
      wait_results_drained();
      set_thresholds(SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                     SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                     SAMPLE_W'($urandom_range(SAMPLE_MAX)));
      run_random_frames(114);
      wait_results_drained();
      // ordered budget in the usual frame-time range
      target  = SAMPLE_W'($urandom_range(40000, 10000));
      warning = target + SAMPLE_W'($urandom_range(10000));
      set_thresholds(target, warning, warning + SAMPLE_W'($urandom_range(20000)));
      run_random_frames(114);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_predictor();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles a quarter of the time, receiver most of the time
      test_threshold_edges();
      test_grade_boundaries();
      test_default_budget();
      test_saturated_thresholds();

      // roles swapped
      wait_results_drained();
      send_idle_pct = 69;
      recv_idle_pct = 25;
      test_zero_thresholds();
      test_critical_under_target();

      // full rate on both sides
      wait_results_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_thresholds();

      // everything sent; let the last results land and watch for strays
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
